/* sv/brb_pkg.sv */
// Shared types and codes for the byte ring buffer.
package brb_pkg;

   localparam int KIND_W  = 3;
   localparam int BYTE_W  = 8;
   localparam int LVL_W   = 9;

   localparam logic [KIND_W-1:0] KIND_ENQUEUE = 3'd0;
   localparam logic [KIND_W-1:0] KIND_DEQUEUE = 3'd1;
   localparam logic [KIND_W-1:0] KIND_PEEK    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_GET     = 3'd3;
   localparam logic [KIND_W-1:0] KIND_DISCARD = 3'd4;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [BYTE_W-1:0] data_in;
      logic [BYTE_W-1:0] index;
      logic [LVL_W-1:0]  count;
   } req_type;

   typedef struct packed {
      logic              ok;
      logic [BYTE_W-1:0] data_out;
      logic [LVL_W-1:0]  removed;
      logic [LVL_W-1:0]  level;
   } rsp_type;

endpackage

/* sv/brb_chan_if.sv */
// Valid/ready channel carrying one payload beat.
interface brb_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* sv/brb_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
module brb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      // hold read data while no read is issued
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

/* sv/byte_ring_buffer.sv */
// Byte FIFO in a ring store with configurable capacity.
//
// Requests arrive on req_chan (valid/ready); one result beat per request
// leaves on rsp_chan. A request is enqueue, dequeue, peek oldest, get at an
// offset from the oldest byte, or discard up to a count of bytes. Each
// result carries ok, the byte read, the bytes removed and the new level.
// Requests are taken one per cycle while rsp_chan does not stall; a result
// passes through the staged request, where the byte store read completes,
// and then the output register. The byte store is a RAM with a registered
// read; pointers and the fill level update at request time, so an
// enqueue is visible to a read issued in the very next cycle.
// When rsp_chan stalls, the output register and one staged request hold
// and req_chan.ready drops until the output register drains.
// Writing csr_wr_data with csr_wr_en sets the capacity in use (0 acts as
// 1, above DEPTH acts as DEPTH) and empties the FIFO; write it only while
// no request is in flight. Reset empties the FIFO and sets the capacity
// to 256 (or DEPTH if smaller); store contents are not cleared.
module byte_ring_buffer #(
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     reset,
   brb_chan_if.sink                 req_chan,
   brb_chan_if.source               rsp_chan,
   input  logic                     csr_wr_en,
   input  logic [brb_pkg::LVL_W-1:0] csr_wr_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int LW = brb_pkg::LVL_W;
   localparam int SW = ((AW > LW) ? AW : LW) + 1;
   localparam logic [LW-1:0] CAP_RST = LW'((DEPTH < 256) ? DEPTH : 256);
   localparam logic [LW-1:0] CAP_MAX = LW'((DEPTH < 511) ? DEPTH : 511);

   logic [LW-1:0] cap_ff, cap_in;
   logic [LW-1:0] level_ff, level_in;
   logic [AW-1:0] wp_ff, wp_in;
   logic [AW-1:0] rp_ff, rp_in;

   logic              s1_valid_ff, s1_valid_in;
   brb_pkg::rsp_type  s1_ff, s1_in;
   logic              s1_use_ram_ff, s1_use_ram_in;
   logic              out_valid_ff, out_valid_in;
   brb_pkg::rsp_type  out_ff, out_in;

   brb_pkg::req_type  req;
   logic              accept;
   logic              out_move;
   logic              ok;
   logic              is_read;
   logic [LW-1:0]     removed_cnt;
   logic [LW-1:0]     step;
   logic [SW-1:0]     rp_sum;
   logic [SW-1:0]     rp_wrap;
   logic [SW-1:0]     wp_sum;
   logic [AW-1:0]     wp_next;
   logic [LW-1:0]     cap_wr;
   logic              ram_wr_en;
   logic              ram_rd_en;
   logic [AW-1:0]     ram_rd_addr;
   logic [brb_pkg::BYTE_W-1:0] ram_rd_data;

   assign req      = req_chan.payload;
   assign out_move = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !s1_valid_ff || out_move;
   assign accept   = req_chan.valid && req_chan.ready;

   assign removed_cnt = (req.count < level_ff) ? req.count : level_ff;

   // single wrap adder on the read pointer: for a request that succeeds the sum stays below twice capacity
   always_comb begin
      case (req.kind)
         brb_pkg::KIND_DEQUEUE: step = LW'(1);
         brb_pkg::KIND_GET:     step = LW'(req.index);
         brb_pkg::KIND_DISCARD: step = removed_cnt;
         default:               step = '0;
      endcase
   end

   assign rp_sum  = SW'(rp_ff) + SW'(step);
   assign rp_wrap = (rp_sum >= SW'(cap_ff)) ? (rp_sum - SW'(cap_ff)) : rp_sum;
   assign wp_sum  = SW'(wp_ff) + SW'(1);
   assign wp_next = (wp_sum == SW'(cap_ff)) ? '0 : AW'(wp_sum);

   always_comb begin
      ok          = 1'b0;
      is_read     = 1'b0;
      wp_in       = wp_ff;
      rp_in       = rp_ff;
      level_in    = level_ff;
      ram_rd_addr = rp_ff;
      s1_in       = '0;
      case (req.kind)
         brb_pkg::KIND_ENQUEUE: begin
            ok = (level_ff != cap_ff);
            if (ok) begin
               wp_in    = wp_next;
               level_in = level_ff + LW'(1);
            end
         end
         brb_pkg::KIND_DEQUEUE: begin
            ok      = (level_ff != '0);
            is_read = ok;
            if (ok) begin
               rp_in    = AW'(rp_wrap);
               level_in = level_ff - LW'(1);
            end
         end
         brb_pkg::KIND_PEEK: begin
            ok      = (level_ff != '0);
            is_read = ok;
         end
         brb_pkg::KIND_GET: begin
            ok          = (LW'(req.index) < level_ff);
            is_read     = ok;
            ram_rd_addr = AW'(rp_wrap);
         end
         brb_pkg::KIND_DISCARD: begin
            ok            = 1'b1;
            rp_in         = AW'(rp_wrap);
            level_in      = level_ff - removed_cnt;
            s1_in.removed = removed_cnt;
         end
         default: begin
            ok = 1'b0;
         end
      endcase
      s1_in.ok    = ok;
      s1_in.level = level_in;
   end

   assign ram_wr_en     = accept && (req.kind == brb_pkg::KIND_ENQUEUE) && ok;
   assign ram_rd_en     = accept && is_read;
   assign s1_use_ram_in = is_read;

   always_comb begin
      if (csr_wr_data == '0) begin
         cap_wr = LW'(1);
      end else if (32'(csr_wr_data) > DEPTH) begin
         cap_wr = CAP_MAX;
      end else begin
         cap_wr = csr_wr_data;
      end
   end

   assign cap_in = csr_wr_en ? cap_wr : cap_ff;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (out_move) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_move ? s1_valid_ff : out_valid_ff;
      out_in          = s1_ff;
      out_in.data_out = s1_use_ram_ff ? ram_rd_data : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CAP_RST;
         level_ff     <= '0;
         wp_ff        <= '0;
         rp_ff        <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cap_ff       <= cap_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_wr_en) begin
            level_ff <= '0;
            wp_ff    <= '0;
            rp_ff    <= '0;
         end else if (accept) begin
            level_ff <= level_in;
            wp_ff    <= wp_in;
            rp_ff    <= rp_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff         <= s1_in;
         s1_use_ram_ff <= s1_use_ram_in;
      end
      if (out_move && s1_valid_ff) begin
         out_ff <= out_in;
      end
   end

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_ff;

   brb_ram #(
      .WIDTH (brb_pkg::BYTE_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wp_ff),
      .wr_data (req.data_in),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

`ifndef SYNTHESIS
   a_level_le_cap: assert property (@(posedge clock) disable iff (reset)
      level_ff <= cap_ff)
      else $error("fill level above capacity");

   a_rp_in_ring: assert property (@(posedge clock) disable iff (reset)
      LW'(rp_ff) < cap_ff)
      else $error("read pointer outside ring");

   a_wp_in_ring: assert property (@(posedge clock) disable iff (reset)
      LW'(wp_ff) < cap_ff)
      else $error("write pointer outside ring");

   a_enqueue_grows: assert property (@(posedge clock) disable iff (reset)
      accept && !csr_wr_en && (req.kind == brb_pkg::KIND_ENQUEUE)
         && (level_ff != cap_ff)
      |=> level_ff == $past(level_ff) + LW'(1))
      else $error("enqueue did not raise fill level");

   a_stall_holds_stage: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_move |=> s1_valid_ff && !$past(accept))
      else $error("staged request lost or overwritten during stall");
`endif

endmodule
